@@ src/fbfla_pkg.sv @@
// ============================================================================
// fbfla_pkg
// Shared types and constants of the fixed-size block pool allocator.
// ============================================================================
package fbfla_pkg;

    // field widths
    localparam int CMD_W      = 2;
    localparam int INDEX_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int OFFSET_W   = 22;
    localparam int COUNT_W    = 11;
    localparam int BYTES_W    = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // rounded block size: block_bytes plus alignment slack
    localparam int RND_W     = 14;
    localparam int PRODUCT_W = 25;

    // register reset values
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;
    localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 13'd8;

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REINIT = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BADIDX = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b1;

    // command sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

@@ src/fixed_block_free_list_allocator.sv @@
// ============================================================================
// fixed_block_free_list_allocator
// Fixed-size block pool allocator: free-block stack in RAM plus a fresh-block
// watermark, with allocate, free and reinit commands.
// ============================================================================
// A command is taken when start is high and busy is low. The block then reads
// the stack top from the free-stack RAM (registered read data) with busy high,
// computes the result in the execute state and raises o_valid for one cycle
// from the result registers; a new command is taken only after the execute
// state of the last one is over.
// The receiver cannot stall, so each result must be captured on its strobe.
// Writing block_bytes starts the rounding unit (reciprocal multiply,
// then scale by the alignment) that derives the aligned block size; busy
// stays high while it runs. Stack entries hold no value until pushed;
// the allocator only ever pops entries it pushed.
// ============================================================================
module fixed_block_free_list_allocator #(
    parameter int MAX_BLOCKS   = 1024,
    parameter int HEADER_BYTES = 32,
    parameter int ALIGN_BYTES  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [fbfla_pkg::CMD_W-1:0]         i_cmd,
    input  logic [fbfla_pkg::INDEX_W-1:0]       i_block_index,
    // result strobe
    output logic                                o_valid,
    output logic [fbfla_pkg::STATUS_W-1:0]      o_status,
    output logic [fbfla_pkg::INDEX_W-1:0]       o_granted_index,
    output logic [fbfla_pkg::OFFSET_W-1:0]      o_byte_offset,
    output logic [fbfla_pkg::COUNT_W-1:0]       o_free_count,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fbfla_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // sizes derived from the parameters
    localparam int AW  = $clog2(MAX_BLOCKS);
    localparam int FW  = $clog2(MAX_BLOCKS + 1);
    localparam int NW  = (FW > fbfla_pkg::COUNT_W) ? FW : fbfla_pkg::COUNT_W;
    localparam int DIV_CYCLES = 2;
    localparam int CNTW = $clog2(DIV_CYCLES + 1);
    localparam int FREE_RST_I = (int'(fbfla_pkg::BLOCK_COUNT_RST) > MAX_BLOCKS)
                              ? MAX_BLOCKS : int'(fbfla_pkg::BLOCK_COUNT_RST);
    localparam int RND_RST_I = ((int'(fbfla_pkg::BLOCK_BYTES_RST) + ALIGN_BYTES - 1)
                              / ALIGN_BYTES) * ALIGN_BYTES;

    // reciprocal of the alignment, exact for every 14-bit dividend
    localparam int     RCP_SH = fbfla_pkg::RND_W + $clog2(ALIGN_BYTES);
    localparam int     RCP_W  = fbfla_pkg::RND_W + 2;
    localparam int     RCP_PW = fbfla_pkg::RND_W + RCP_W;
    localparam longint RCP_I  = ((longint'(1) << RCP_SH) + longint'(ALIGN_BYTES) - 1)
                              / longint'(ALIGN_BYTES);

    localparam logic [NW-1:0]                  MAX_N    = NW'(MAX_BLOCKS);
    localparam logic [FW-1:0]                  MAX_F    = FW'(MAX_BLOCKS);
    localparam logic [FW-1:0]                  FREE_RST = FW'(FREE_RST_I);
    localparam logic [fbfla_pkg::RND_W-1:0]    RND_RST  = fbfla_pkg::RND_W'(RND_RST_I);
    localparam logic [RCP_W-1:0]               RCP      = RCP_W'(RCP_I);
    localparam logic [fbfla_pkg::RND_W-1:0]    ALIGN_R  = fbfla_pkg::RND_W'(ALIGN_BYTES);

    // control state
    fbfla_pkg::t_state                  r_state, n_state;
    logic [FW-1:0]                      r_depth, n_depth;
    logic [fbfla_pkg::COUNT_W-1:0]      r_next_fresh, n_next_fresh;
    logic [FW-1:0]                      r_free, n_free;
    logic [fbfla_pkg::COUNT_W-1:0]      r_block_count, n_block_count;
    logic [fbfla_pkg::RND_W-1:0]        r_rnd, n_rnd;
    logic                               r_valid, n_valid;
    logic                               r_div_busy, n_div_busy;
    logic [CNTW-1:0]                    r_div_cnt, n_div_cnt;

    // payload registers
    logic [fbfla_pkg::CMD_W-1:0]        r_cmd, n_cmd;
    logic [fbfla_pkg::INDEX_W-1:0]      r_idx, n_idx;
    logic [fbfla_pkg::STATUS_W-1:0]     r_status, n_status;
    logic [fbfla_pkg::INDEX_W-1:0]      r_granted, n_granted;
    logic [fbfla_pkg::OFFSET_W-1:0]     r_offset, n_offset;
    logic [fbfla_pkg::COUNT_W-1:0]      r_count_out, n_count_out;
    logic [fbfla_pkg::RND_W-1:0]        r_div_src, n_div_src;
    logic [fbfla_pkg::RND_W-1:0]        r_div_q, n_div_q;

    // stack ram signals
    logic                               w_ram_we;
    logic [AW-1:0]                      w_ram_waddr;
    logic                               w_ram_re;
    logic [AW-1:0]                      w_ram_raddr;
    logic [fbfla_pkg::INDEX_W-1:0]      w_ram_rdata;

    // datapath helpers
    logic                               w_accept;
    logic [NW-1:0]                      w_pool;
    logic [fbfla_pkg::COUNT_W-1:0]      w_grant_sel;
    logic [fbfla_pkg::PRODUCT_W-1:0]    w_product;
    logic [RCP_PW-1:0]                  w_div_prod;
    logic [fbfla_pkg::RND_W-1:0]        w_div_q;
    logic [NW-1:0]                      w_free_ext;
    logic [fbfla_pkg::RND_W-1:0]        w_div_start;

    assign busy        = (r_state != fbfla_pkg::ST_IDLE) || r_div_busy;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // pool size in use: block_count clamped to the stack depth
    assign w_pool = (NW'(r_block_count) > MAX_N) ? MAX_N : NW'(r_block_count);

    // stack top read is issued with the command transfer
    assign w_ram_re    = w_accept;
    assign w_ram_raddr = AW'(r_depth - FW'(1));
    assign w_ram_waddr = AW'(r_depth);

    // offset product of the selected grant and the rounded size
    assign w_product = fbfla_pkg::PRODUCT_W'(w_grant_sel)
                     * fbfla_pkg::PRODUCT_W'(r_rnd);

    // rounding unit: quotient of (block_bytes + align - 1) by align
    assign w_div_prod  = RCP_PW'(r_div_src) * RCP_PW'(RCP);
    assign w_div_q     = fbfla_pkg::RND_W'(w_div_prod >> RCP_SH);
    assign w_div_start = fbfla_pkg::RND_W'(i_cfg_data)
                       + fbfla_pkg::RND_W'(ALIGN_BYTES - 1);

    fbfla_ram #(
        .WIDTH (fbfla_pkg::INDEX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (r_idx),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // next state, command execution and configuration
    always_comb begin
        n_state       = r_state;
        n_depth       = r_depth;
        n_next_fresh  = r_next_fresh;
        n_free        = r_free;
        n_block_count = r_block_count;
        n_rnd         = r_rnd;
        n_valid       = 1'b0;
        n_div_busy    = r_div_busy;
        n_div_cnt     = r_div_cnt;
        n_cmd         = r_cmd;
        n_idx         = r_idx;
        n_status      = r_status;
        n_granted     = r_granted;
        n_offset      = r_offset;
        n_count_out   = r_count_out;
        n_div_src     = r_div_src;
        n_div_q       = r_div_q;
        w_ram_we      = 1'b0;
        w_grant_sel   = r_next_fresh;
        w_free_ext    = '0;

        // command sequencer
        case (r_state)
            fbfla_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_cmd   = i_cmd;
                    n_idx   = i_block_index;
                    n_state = fbfla_pkg::ST_EXEC;
                end
            end
            fbfla_pkg::ST_EXEC: begin
                n_state   = fbfla_pkg::ST_IDLE;
                n_valid   = 1'b1;
                n_status  = fbfla_pkg::STAT_OK;
                n_granted = '0;
                n_offset  = '0;
                case (r_cmd)
                    fbfla_pkg::CMD_ALLOC: begin
                        if (r_depth != '0) begin
                            w_grant_sel = fbfla_pkg::COUNT_W'(w_ram_rdata);
                            n_depth     = r_depth - FW'(1);
                        end else if (NW'(r_next_fresh) < w_pool) begin
                            w_grant_sel  = r_next_fresh;
                            n_next_fresh = r_next_fresh + fbfla_pkg::COUNT_W'(1);
                        end else begin
                            n_status = fbfla_pkg::STAT_EMPTY;
                        end
                        if (n_status == fbfla_pkg::STAT_OK) begin
                            n_granted = fbfla_pkg::INDEX_W'(w_grant_sel);
                            n_offset  = fbfla_pkg::OFFSET_W'(w_product
                                      + fbfla_pkg::PRODUCT_W'(HEADER_BYTES));
                            if (r_free != '0) begin
                                n_free = r_free - FW'(1);
                            end
                        end
                    end
                    fbfla_pkg::CMD_FREE: begin
                        if (NW'(r_idx) >= w_pool) begin
                            n_status = fbfla_pkg::STAT_BADIDX;
                        end else begin
                            // push unless the stack is full
                            if (r_depth < MAX_F) begin
                                w_ram_we = 1'b1;
                                n_depth  = r_depth + FW'(1);
                            end
                            if (r_free < MAX_F) begin
                                n_free = r_free + FW'(1);
                            end
                        end
                    end
                    fbfla_pkg::CMD_REINIT: begin
                        n_depth      = '0;
                        n_next_fresh = '0;
                        n_free       = FW'(w_pool);
                    end
                    default: begin
                    end
                endcase
                w_free_ext  = NW'(n_free);
                n_count_out = w_free_ext[fbfla_pkg::COUNT_W-1:0];
            end
            default: begin
                n_state = fbfla_pkg::ST_IDLE;
            end
        endcase

        // rounding unit: quotient first, then scale back by the alignment
        if (r_div_busy) begin
            n_div_cnt = r_div_cnt - CNTW'(1);
            if (r_div_cnt == CNTW'(DIV_CYCLES)) begin
                n_div_q = w_div_q;
            end else begin
                n_div_busy = 1'b0;
                n_rnd      = r_div_q * ALIGN_R;
            end
        end

        // configuration register transfer
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fbfla_pkg::CFG_BLOCK_COUNT: begin
                    n_block_count = i_cfg_data[fbfla_pkg::COUNT_W-1:0];
                end
                fbfla_pkg::CFG_BLOCK_BYTES: begin
                    n_div_src  = w_div_start;
                    n_div_cnt  = CNTW'(DIV_CYCLES);
                    n_div_busy = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fbfla_pkg::ST_IDLE;
            r_depth       <= '0;
            r_next_fresh  <= '0;
            r_free        <= FREE_RST;
            r_block_count <= fbfla_pkg::BLOCK_COUNT_RST;
            r_rnd         <= RND_RST;
            r_valid       <= 1'b0;
            r_div_busy    <= 1'b0;
            r_div_cnt     <= '0;
        end else begin
            r_state       <= n_state;
            r_depth       <= n_depth;
            r_next_fresh  <= n_next_fresh;
            r_free        <= n_free;
            r_block_count <= n_block_count;
            r_rnd         <= n_rnd;
            r_valid       <= n_valid;
            r_div_busy    <= n_div_busy;
            r_div_cnt     <= n_div_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_status    <= n_status;
        r_granted   <= n_granted;
        r_offset    <= n_offset;
        r_count_out <= n_count_out;
        r_div_src   <= n_div_src;
        r_div_q     <= n_div_q;
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_granted_index = r_granted;
    assign o_byte_offset   = r_offset;
    assign o_free_count    = r_count_out;

endmodule

@@ src/fbfla_ram.sv @@
// ============================================================================
// fbfla_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module fbfla_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/fbfla_chk.sv @@
// ============================================================================
// fbfla_chk
// Port-level checks of the block allocator, bound to the top level.
// ============================================================================
module fbfla_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_valid,
    input logic [fbfla_pkg::STATUS_W-1:0]      o_status,
    input logic [fbfla_pkg::INDEX_W-1:0]       o_granted_index,
    input logic [fbfla_pkg::OFFSET_W-1:0]      o_byte_offset
);

    // every command transfer yields its result strobe
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("missing result after command transfer");

    // the allocator is busy while a command executes
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low during command execution");

    // results are single-cycle strobes
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // failed commands grant nothing
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != fbfla_pkg::STAT_OK)
            |-> (o_granted_index == '0 && o_byte_offset == '0))
        else $error("grant reported on failed command");

    // status is always a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == fbfla_pkg::STAT_OK || o_status == fbfla_pkg::STAT_EMPTY
                     || o_status == fbfla_pkg::STAT_BADIDX))
        else $error("undefined status code");

endmodule

bind fixed_block_free_list_allocator fbfla_chk u_fbfla_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_status        (o_status),
    .o_granted_index (o_granted_index),
    .o_byte_offset   (o_byte_offset)
);

@@ test/fbfla_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fbfla_checker
// Watches the command, configuration and result ports of the block pool
// allocator, predicts every result from its own copy of the pool state and
// compares each strobed result field by field with the oldest prediction.
// ============================================================================
module fbfla_checker
    import fbfla_pkg::*;
#(
    parameter int MAX_BLOCKS   = 1024,
    parameter int HEADER_BYTES = 32,
    parameter int ALIGN_BYTES  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    input  logic                  busy,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [INDEX_W-1:0]    i_block_index,
    // result strobe
    input  logic                  o_valid,
    input  logic [STATUS_W-1:0]   o_status,
    input  logic [INDEX_W-1:0]    o_granted_index,
    input  logic [OFFSET_W-1:0]   o_byte_offset,
    input  logic [COUNT_W-1:0]    o_free_count,
    // configuration write channel
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // totals handed to the testbench top
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_checked
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  granted;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  free_count;
    } t_grant;

    t_grant expected_grants[$];

    // predicted pool state
    logic [INDEX_W-1:0] recycled [MAX_BLOCKS];
    int recycled_depth;
    int fresh_mark;
    int free_total;
    int pool_count;
    int pool_bytes;

    int mismatches = 0;
    int checked    = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic reset_pool_model();
        pool_count     = int'(BLOCK_COUNT_RST);
        pool_bytes     = int'(BLOCK_BYTES_RST);
        recycled_depth = 0;
        fresh_mark     = 0;
        free_total     = (pool_count > MAX_BLOCKS) ? MAX_BLOCKS : pool_count;
        expected_grants.delete();
    endtask

    // work out the result of one command and advance the pool state
    task automatic apply_pool_cmd(input logic [CMD_W-1:0] cmd, input int idx);
        int             pool;
        int             granted;
        longint         rounded;
        longint         offset;
        logic [STATUS_W-1:0] status;
        bit             ok;
        t_grant         res;
        pool    = (pool_count > MAX_BLOCKS) ? MAX_BLOCKS : pool_count;
        rounded = ((longint'(pool_bytes) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        granted = 0;
        offset  = 0;
        status  = STAT_OK;
        ok      = 1'b1;
        case (cmd)
            CMD_ALLOC: begin
                // most recently freed block first, then the fresh watermark
                if (recycled_depth > 0) begin
                    recycled_depth--;
                    granted = int'(recycled[recycled_depth]);
                end else if (fresh_mark < pool) begin
                    granted = fresh_mark;
                    fresh_mark++;
                end else begin
                    ok     = 1'b0;
                    status = STAT_EMPTY;
                end
                if (ok) begin
                    if (free_total > 0) free_total--;
                    offset = HEADER_BYTES + longint'(granted) * rounded;
                end
            end
            CMD_FREE: begin
                if (idx >= pool) begin
                    status = STAT_BADIDX;
                end else begin
                    // push dropped when the stack is full, count still saturates
                    if (recycled_depth < MAX_BLOCKS) begin
                        recycled[recycled_depth] = INDEX_W'(idx);
                        recycled_depth++;
                    end
                    if (free_total < MAX_BLOCKS) free_total++;
                end
            end
            CMD_REINIT: begin
                recycled_depth = 0;
                fresh_mark     = 0;
                free_total     = pool;
            end
            default: ;
        endcase
        res.status     = status;
        res.granted    = INDEX_W'(granted);
        res.offset     = OFFSET_W'(offset);
        res.free_count = COUNT_W'(free_total);
        expected_grants.push_back(res);
    endtask

    // watch the channels at each edge
    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            reset_pool_model();
        end else begin
            // register write transfer
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_BLOCK_COUNT)
                    pool_count = int'(i_cfg_data[COUNT_W-1:0]);
                else if (i_cfg_index == CFG_BLOCK_BYTES)
                    pool_bytes = int'(i_cfg_data[BYTES_W-1:0]);
            end
            // command transfer
            if (start && !busy)
                apply_pool_cmd(i_cmd, int'(i_block_index));
            // result strobe
            if (o_valid) begin
                if (expected_grants.size() == 0) begin
                    report_mismatch($sformatf("result with no command pending (status %0d)",
                                              o_status));
                end else begin
                    want = expected_grants.pop_front();
                    checked++;
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status got %0d, expected %0d",
                                                  o_status, want.status));
                    if (o_granted_index !== want.granted)
                        report_mismatch($sformatf("granted_index got %0d, expected %0d",
                                                  o_granted_index, want.granted));
                    if (o_byte_offset !== want.offset)
                        report_mismatch($sformatf("byte_offset got %0d, expected %0d",
                                                  o_byte_offset, want.offset));
                    if (o_free_count !== want.free_count)
                        report_mismatch($sformatf("free_count got %0d, expected %0d",
                                                  o_free_count, want.free_count));
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_grants.size();
        o_checked    <= checked;
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Testbench top of the block pool allocator: drives register writes and
// commands with random idle gaps, and reports the verdict from the checker.
// ============================================================================
module tb;
    import fbfla_pkg::*;

    localparam int MAX_BLOCKS   = 1024;
    localparam int HEADER_BYTES = 32;
    localparam int ALIGN_BYTES  = 8;
    localparam int CYCLE_LIMIT  = 600000;

    // command code with no defined operation
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  start         = 1'b0;
    logic [CMD_W-1:0]      i_cmd         = CMD_ALLOC;
    logic [INDEX_W-1:0]    i_block_index = '0;
    logic                  i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_BLOCK_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    logic                  busy;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [INDEX_W-1:0]    o_granted_index;
    logic [OFFSET_W-1:0]   o_byte_offset;
    logic [COUNT_W-1:0]    o_free_count;
    logic                  o_cfg_ready;

    int mismatches;
    int pending;
    int checked;

    // stimulus bookkeeping
    int cycles     = 0;
    int cur_count  = int'(BLOCK_COUNT_RST);
    bit no_idle    = 1'b0;
    int n_alloc    = 0;
    int n_free     = 0;
    int n_reinit   = 0;
    int n_unknown  = 0;
    int n_settings = 0;

    fixed_block_free_list_allocator #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .HEADER_BYTES(HEADER_BYTES),
        .ALIGN_BYTES (ALIGN_BYTES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_block_index  (i_block_index),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_granted_index(o_granted_index),
        .o_byte_offset  (o_byte_offset),
        .o_free_count   (o_free_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    fbfla_checker #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .HEADER_BYTES(HEADER_BYTES),
        .ALIGN_BYTES (ALIGN_BYTES)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_block_index  (i_block_index),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_granted_index(o_granted_index),
        .o_byte_offset  (o_byte_offset),
        .o_free_count   (o_free_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending", cycles, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // idle gap before a command: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // free index: mostly a block of the pool, some edges and some noise
    function automatic int pick_index();
        int pool;
        int r;
        pool = (cur_count > MAX_BLOCKS) ? MAX_BLOCKS : cur_count;
        r    = $urandom_range(0, 99);
        if (pool == 0 || r < 15) return $urandom_range(0, 1023);
        if (r < 20) return pool - 1;
        if (r < 25) return (pool > 1023) ? 1023 : pool;
        return $urandom_range(0, pool - 1);
    endfunction

    // one command transfer; start stays high so a following command can go
    // out with no gap
    task automatic issue(input logic [CMD_W-1:0] cmd, input int idx, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_block_index <= INDEX_W'(idx);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case (cmd)
            CMD_ALLOC:  n_alloc++;
            CMD_FREE:   n_free++;
            CMD_REINIT: n_reinit++;
            default:    n_unknown++;
        endcase
    endtask

    // let every outstanding result arrive
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write both registers in back-to-back transfers
    task automatic set_pool(input int count, input int bytes);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_BLOCK_COUNT;
        i_cfg_data  <= CFG_DATA_W'(count);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_BLOCK_BYTES;
        i_cfg_data  <= CFG_DATA_W'(bytes);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_count = count;
        n_settings++;
    endtask

    // stimulus
    initial begin
        int items;
        int r;
        int count;
        int bytes;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: fresh grants, stack reuse, top index, unknown command
        issue(CMD_ALLOC, 0, 0);
        issue(CMD_ALLOC, 0, 0);
        issue(CMD_FREE, 1, 0);
        issue(CMD_FREE, 0, 1);
        issue(CMD_ALLOC, 0, 0);
        issue(CMD_FREE, 1023, 0);
        issue(CMD_ALLOC, 0, 2);
        issue(CMD_UNUSED, 1023, 0);
        issue(CMD_REINIT, 0, 0);
        drain();

        // small pool, 4096-byte blocks: bad index, empty pool
        set_pool(5, 4096);
        issue(CMD_FREE, 5, 0);
        issue(CMD_FREE, 1023, 0);
        issue(CMD_REINIT, 0, 0);
        repeat (5) issue(CMD_ALLOC, 0, 0);
        issue(CMD_ALLOC, 0, 0);
        issue(CMD_FREE, 4, 0);
        issue(CMD_ALLOC, 0, 0);
        drain();

        // no blocks at all, zero block size
        set_pool(0, 0);
        issue(CMD_REINIT, 0, 0);
        issue(CMD_ALLOC, 0, 0);
        issue(CMD_FREE, 0, 0);
        drain();

        // oversized count clamps, widest block wraps the offset
        set_pool(2047, 8191);
        issue(CMD_REINIT, 0, 0);
        issue(CMD_FREE, 1023, 0);
        issue(CMD_ALLOC, 0, 0);
        drain();

        // random phases, each with its own pool settings
        for (int ph = 0; ph < 10; ph++) begin
            r = $urandom_range(0, 9);
            case (r)
                0:       count = 0;
                1:       count = 1;
                2:       count = 1024;
                3:       count = 2047;
                4, 5, 6: count = $urandom_range(2, 24);
                default: count = $urandom_range(25, 1024);
            endcase
            r = $urandom_range(0, 9);
            case (r)
                0:       bytes = 0;
                1:       bytes = 1;
                2:       bytes = 4096;
                3:       bytes = 8191;
                default: bytes = $urandom_range(1, 4096);
            endcase
            set_pool(count, bytes);
            no_idle = ($urandom_range(0, 3) == 0);
            // without a reinit the old pool state runs on under the new count
            if ($urandom_range(0, 9) < 7) issue(CMD_REINIT, 0, pick_gap());
            items = $urandom_range(60, 120);
            for (int k = 0; k < items; k++) begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    issue(CMD_ALLOC, $urandom_range(0, 1023), pick_gap());
                else if (r < 92)
                    issue(CMD_FREE, pick_index(), pick_gap());
                else if (r < 96)
                    issue(CMD_REINIT, $urandom_range(0, 1023), pick_gap());
                else
                    issue(CMD_UNUSED, $urandom_range(0, 1023), pick_gap());
            end
            drain();
        end

        $display("covered %0d commands: %0d allocate, %0d free, %0d reinit, %0d unknown",
                 n_alloc + n_free + n_reinit + n_unknown, n_alloc, n_free, n_reinit,
                 n_unknown);
        $display("%0d results compared over %0d pool settings",
                 checked, n_settings);
        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/fbfla_pkg.sv
src/fbfla_ram.sv
src/fixed_block_free_list_allocator.sv
src/fbfla_chk.sv
test/fbfla_checker.sv
test/tb.sv
